// ===== rtl/cslp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslp_pkg
// Shared types and codes for the critical-section length predictor.
// ----------------------------------------------------------------------------
package cslp_pkg;

    // Field widths fixed by the item formats
    localparam int LOC_W   = 7;
    localparam int TS_W    = 64;
    localparam int PRED_W  = 32;
    localparam int STAT_W  = 2;
    localparam int LIM_W   = 31;
    localparam int IN_W    = 72;   // location + timestamp, padded to bytes
    localparam int OUT_W   = 48;   // location_out + prediction + status, padded
    localparam int PADDR_W = 3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Event kinds
    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_LONG_LIMIT  = 1'b0;
    localparam logic REG_SMALL_LIMIT = 1'b1;

    // Reset values of the limits
    localparam logic [LIM_W-1:0] LONG_LIMIT_RST  = 31'd10000;
    localparam logic [LIM_W-1:0] SMALL_LIMIT_RST = 31'd1000;

    // One location table entry
    typedef struct packed {
        logic signed [PRED_W-1:0] pred;
        logic [TS_W-1:0]          start;
    } entry_t;

    // Stack commands and status
    typedef struct packed {
        logic push;
        logic pop;
    } stk_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stk_status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START_WR,
        S_END_STACK,
        S_END_TABLE,
        S_END_UPD,
        S_RESULT
    } state_t;

endpackage

// ===== rtl/cslp_loc_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslp_loc_table
// Per-location memory of prediction and start time, one read and one write
// port, registered read data held until the next read.
// ----------------------------------------------------------------------------
module cslp_loc_table #(
    parameter int LOCATIONS = 128,
    parameter int LW        = 7
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [LW-1:0]     rd_idx,
    input  logic              wr_en,
    input  logic [LW-1:0]     wr_idx,
    input  cslp_pkg::entry_t  wr_data,
    output cslp_pkg::entry_t  rd_data
);

    cslp_pkg::entry_t mem [LOCATIONS];
    cslp_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cslp_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslp_stack
// Nesting stack of locations held in a memory, with its fill count.
// ----------------------------------------------------------------------------
module cslp_stack #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cslp_pkg::stk_cmd_t              cmd,
    input  logic [cslp_pkg::LOC_W-1:0]      wr_loc,
    output cslp_pkg::stk_status_t           st,
    output logic [cslp_pkg::LOC_W-1:0]      rd_loc
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [cslp_pkg::LOC_W-1:0] mem [STACK_DEPTH];
    logic [cslp_pkg::LOC_W-1:0] rd_loc_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              top_idx;

    assign st.empty = (count_reg == '0);
    assign st.full  = (count_reg == CW'(STACK_DEPTH));
    assign top_idx  = count_reg - CW'(1);

    // Advance the fill count
    always_comb begin
        count_next = count_reg;
        if (cmd.push && !st.full) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop && !st.empty) begin
            count_next = top_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Push writes above the top, pop reads the top
    always_ff @(posedge aclk) begin
        if (cmd.push && !st.full) begin
            mem[SW'(count_reg)] <= wr_loc;
        end
        if (cmd.pop && !st.empty) begin
            rd_loc_reg <= mem[SW'(top_idx)];
        end
    end

    assign rd_loc = rd_loc_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop && !cmd.push && !st.empty) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not lower count");

endmodule

// ===== rtl/cslp_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslp_update
// Prediction update from the stored prediction and the measured duration.
// ----------------------------------------------------------------------------
module cslp_update (
    input  logic signed [cslp_pkg::PRED_W-1:0] pred_old,
    input  logic signed [cslp_pkg::PRED_W-1:0] dur,
    input  logic [cslp_pkg::LIM_W-1:0]         long_limit,
    input  logic [cslp_pkg::LIM_W-1:0]         small_limit,
    output logic signed [cslp_pkg::PRED_W-1:0] pred_new
);

    logic signed [33:0] p3;
    logic signed [33:0] p3_adj;
    logic signed [33:0] p_q;
    logic signed [32:0] d_adj;
    logic signed [32:0] d_q;
    logic signed [33:0] blend;
    logic signed [31:0] doubled;
    logic               is_long;
    logic               is_small;

    // Three quarters of the prediction, truncating toward zero
    assign p3     = {{2{pred_old[31]}}, pred_old} + {pred_old[31], pred_old, 1'b0};
    assign p3_adj = p3 + (p3[33] ? 34'sd3 : 34'sd0);
    assign p_q    = p3_adj >>> 2;

    // Quarter of the duration, truncating toward zero
    assign d_adj  = {dur[31], dur} + (dur[31] ? 33'sd3 : 33'sd0);
    assign d_q    = d_adj >>> 2;
    assign blend  = p_q + {d_q[32], d_q};

    // Doubling saturates at the largest positive value
    assign doubled  = pred_old[30] ? 32'sh7FFF_FFFF : {pred_old[30:0], 1'b0};
    assign is_long  = dur > $signed({1'b0, long_limit});
    assign is_small = !pred_old[31] && (pred_old != '0)
                      && (pred_old < $signed({1'b0, small_limit}));

    always_comb begin
        if (pred_old == '0) begin
            pred_new = dur;
        end else if (is_long && is_small) begin
            pred_new = doubled;
        end else begin
            pred_new = blend[31:0];
        end
    end

endmodule

// ===== rtl/cslp_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslp_regs
// Configuration registers behind the APB port.
// ----------------------------------------------------------------------------
module cslp_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cslp_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [cslp_pkg::LIM_W-1:0]          long_limit,
    output logic [cslp_pkg::LIM_W-1:0]          small_limit
);

    logic [cslp_pkg::LIM_W-1:0] long_limit_reg;
    logic [cslp_pkg::LIM_W-1:0] small_limit_reg;
    logic                       wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;

    // Write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_limit_reg  <= cslp_pkg::LONG_LIMIT_RST;
            small_limit_reg <= cslp_pkg::SMALL_LIMIT_RST;
        end else if (wr_fire) begin
            case (paddr[2])
                cslp_pkg::REG_LONG_LIMIT:  long_limit_reg  <= pwdata[30:0];
                cslp_pkg::REG_SMALL_LIMIT: small_limit_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[2])
            cslp_pkg::REG_LONG_LIMIT:  prdata = {1'b0, long_limit_reg};
            cslp_pkg::REG_SMALL_LIMIT: prdata = {1'b0, small_limit_reg};
            default:                   prdata = '0;
        endcase
    end

    assign long_limit  = long_limit_reg;
    assign small_limit = small_limit_reg;

endmodule

// ===== rtl/critical_section_length_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// critical_section_length_predictor
// Per-location critical-section length prediction with a nesting stack.
// ----------------------------------------------------------------------------
// A start event reads the location table, then writes the start time and
// loads the result. An end event pops the stack, reads the table, forms the
// duration, then writes the new prediction and loads the result; an end on
// an empty stack only loads the empty result. One item is in flight at a
// time; a waiting result stalls only the final step. Reset clears every
// location table entry in turn, and s_tready stays low until it is done.
// ----------------------------------------------------------------------------
module critical_section_length_predictor #(
    parameter int LOCATIONS   = 128,
    parameter int STACK_DEPTH = 128
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cslp_pkg::IN_W-1:0]           s_tdata,   // location, timestamp
    input  logic                                s_tuser,   // op
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cslp_pkg::OUT_W-1:0]          m_tdata,   // location_out, prediction, status
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cslp_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int LW = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;

    cslp_pkg::state_t state_reg, state_next;

    logic [cslp_pkg::LOC_W-1:0]         loc_reg, loc_next;
    logic [cslp_pkg::TS_W-1:0]          ts_reg, ts_next;
    logic [cslp_pkg::STAT_W-1:0]        status_reg, status_next;
    logic signed [cslp_pkg::PRED_W-1:0] dur_reg, dur_next;
    logic [LW-1:0]                      clr_idx_reg, clr_idx_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [cslp_pkg::OUT_W-1:0]         m_tdata_reg, m_tdata_next;

    logic [cslp_pkg::LOC_W-1:0]         loc_mod_tbl [128];
    logic [cslp_pkg::LOC_W-1:0]         s_loc;
    logic                               s_acc;
    logic                               out_free;

    logic                               tbl_rd_en, tbl_wr_en;
    logic [LW-1:0]                      tbl_rd_idx, tbl_wr_idx;
    cslp_pkg::entry_t                   tbl_wr_data, tbl_rd_data;

    cslp_pkg::stk_cmd_t                 stk_cmd;
    cslp_pkg::stk_status_t              stk_st;
    logic [cslp_pkg::LOC_W-1:0]         stk_rd_loc;

    logic [cslp_pkg::LIM_W-1:0]         long_limit, small_limit;
    logic signed [cslp_pkg::PRED_W-1:0] pred_new;

    // Wrap the location into the table range
    for (genvar i = 0; i < 128; i++) begin : g_loc_mod
        assign loc_mod_tbl[i] = cslp_pkg::LOC_W'(i % LOCATIONS);
    end

    assign s_loc    = loc_mod_tbl[s_tdata[6:0]];
    assign s_tready = (state_reg == cslp_pkg::S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    cslp_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .long_limit  (long_limit),
        .small_limit (small_limit)
    );

    cslp_loc_table #(
        .LOCATIONS (LOCATIONS),
        .LW        (LW)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (tbl_rd_en),
        .rd_idx  (tbl_rd_idx),
        .wr_en   (tbl_wr_en),
        .wr_idx  (tbl_wr_idx),
        .wr_data (tbl_wr_data),
        .rd_data (tbl_rd_data)
    );

    cslp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (stk_cmd),
        .wr_loc   (s_loc),
        .st       (stk_st),
        .rd_loc   (stk_rd_loc)
    );

    cslp_update u_update (
        .pred_old    (tbl_rd_data.pred),
        .dur         (dur_reg),
        .long_limit  (long_limit),
        .small_limit (small_limit),
        .pred_new    (pred_new)
    );

    // Sequencer: next state, memory controls and result load
    always_comb begin
        state_next    = state_reg;
        loc_next      = loc_reg;
        ts_next       = ts_reg;
        status_next   = status_reg;
        dur_next      = dur_reg;
        clr_idx_next  = clr_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        tbl_rd_en     = 1'b0;
        tbl_rd_idx    = LW'(s_loc);
        tbl_wr_en     = 1'b0;
        tbl_wr_idx    = LW'(loc_reg);
        tbl_wr_data   = tbl_rd_data;
        stk_cmd       = '0;

        case (state_reg)
            cslp_pkg::S_CLEAR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_idx  = clr_idx_reg;
                tbl_wr_data = '0;
                clr_idx_next = clr_idx_reg + LW'(1);
                if (clr_idx_reg == LW'(LOCATIONS - 1)) begin
                    state_next = cslp_pkg::S_IDLE;
                end
            end
            cslp_pkg::S_IDLE: begin
                if (s_acc) begin
                    ts_next = s_tdata[70:7];
                    if (s_tuser == cslp_pkg::OP_START) begin
                        loc_next     = s_loc;
                        tbl_rd_en    = 1'b1;
                        stk_cmd.push = 1'b1;
                        status_next  = stk_st.full ? cslp_pkg::ST_FULL : cslp_pkg::ST_OK;
                        state_next   = cslp_pkg::S_START_WR;
                    end else if (stk_st.empty) begin
                        state_next = cslp_pkg::S_RESULT;
                    end else begin
                        stk_cmd.pop = 1'b1;
                        state_next  = cslp_pkg::S_END_STACK;
                    end
                end
            end
            cslp_pkg::S_START_WR: begin
                if (out_free) begin
                    tbl_wr_en         = 1'b1;
                    tbl_wr_data.start = ts_reg;
                    m_tvalid_next     = 1'b1;
                    m_tdata_next      = {7'b0, status_reg, tbl_rd_data.pred, loc_reg};
                    state_next        = cslp_pkg::S_IDLE;
                end
            end
            cslp_pkg::S_END_STACK: begin
                loc_next   = stk_rd_loc;
                tbl_rd_en  = 1'b1;
                tbl_rd_idx = LW'(stk_rd_loc);
                state_next = cslp_pkg::S_END_TABLE;
            end
            cslp_pkg::S_END_TABLE: begin
                dur_next   = ts_reg[31:0] - tbl_rd_data.start[31:0];
                state_next = cslp_pkg::S_END_UPD;
            end
            cslp_pkg::S_END_UPD: begin
                if (out_free) begin
                    tbl_wr_en        = 1'b1;
                    tbl_wr_data.pred = pred_new;
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = {7'b0, cslp_pkg::ST_OK, pred_new, loc_reg};
                    state_next       = cslp_pkg::S_IDLE;
                end
            end
            cslp_pkg::S_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, cslp_pkg::ST_EMPTY, 32'b0, 7'b0};
                    state_next    = cslp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cslp_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cslp_pkg::S_CLEAR;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        loc_reg     <= loc_next;
        ts_reg      <= ts_next;
        status_reg  <= status_next;
        dur_reg     <= dur_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_empty_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tuser == cslp_pkg::OP_END) && stk_st.empty)
        |=> (state_reg == cslp_pkg::S_RESULT))
        else $error("end on empty stack not reported");

    a_tbl_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr_en |-> (state_reg == cslp_pkg::S_CLEAR || state_reg == cslp_pkg::S_START_WR
                       || state_reg == cslp_pkg::S_END_UPD))
        else $error("table written outside a write step");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("waiting result overwritten");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the critical-section length predictor. Start and
// end events go in on the input stream with random gaps while the result
// stream stalls at random. A scoreboard keeps its own copy of the location
// tables, the nesting stack and the two limits, works out each result and
// compares the result stream with it field by field. The limits are
// rewritten over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int LOCATIONS   = 128;
    localparam int STACK_DEPTH = 128;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 8;

    // One expected item on the result stream
    typedef struct packed {
        logic [cslp_pkg::LOC_W-1:0]         loc;
        logic signed [cslp_pkg::PRED_W-1:0] pred;
        logic [cslp_pkg::STAT_W-1:0]        status;
    } length_result_t;

    // Scoreboard: own copy of the tables, the stack and the limits
    class length_scoreboard;
        logic signed [cslp_pkg::PRED_W-1:0] lengths[LOCATIONS];
        logic [cslp_pkg::TS_W-1:0]          started[LOCATIONS];
        logic [cslp_pkg::LOC_W-1:0]         nest[STACK_DEPTH];
        int                                 depth;
        logic [cslp_pkg::LIM_W-1:0]         long_limit;
        logic [cslp_pkg::LIM_W-1:0]         small_limit;
        length_result_t                     pending[$];
        int                                 errors;

        function new();
            for (int i = 0; i < LOCATIONS; i++) begin
                lengths[i] = '0;
                started[i] = '0;
            end
            for (int i = 0; i < STACK_DEPTH; i++) nest[i] = '0;
            depth       = 0;
            long_limit  = cslp_pkg::LONG_LIMIT_RST;
            small_limit = cslp_pkg::SMALL_LIMIT_RST;
            errors      = 0;
        endfunction

        function void set_limit(logic idx, logic [31:0] value);
            if (idx == cslp_pkg::REG_LONG_LIMIT) long_limit = value[cslp_pkg::LIM_W-1:0];
            else small_limit = value[cslp_pkg::LIM_W-1:0];
        endfunction

        // Update rule for one location's prediction
        function logic signed [cslp_pkg::PRED_W-1:0] next_length(
            logic signed [cslp_pkg::PRED_W-1:0] p,
            logic signed [cslp_pkg::PRED_W-1:0] d);
            longint p64;
            longint d64;
            longint r;
            p64 = p;
            d64 = d;
            if (p64 == 0) return d;
            if (d64 > longint'(long_limit) && p64 > 0 && p64 < longint'(small_limit)) begin
                r = p64 * 2;
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                return r[cslp_pkg::PRED_W-1:0];
            end
            r = (p64 * 3) / 4 + d64 / 4;
            return r[cslp_pkg::PRED_W-1:0];
        endfunction

        // Work out the result of one accepted event and queue it
        function void note_event(logic op, logic [cslp_pkg::LOC_W-1:0] loc,
                                 logic [cslp_pkg::TS_W-1:0] ts);
            length_result_t                     res;
            logic [cslp_pkg::LOC_W-1:0]         at;
            logic [cslp_pkg::TS_W-1:0]          span;
            logic signed [cslp_pkg::PRED_W-1:0] d;
            if (op == cslp_pkg::OP_START) begin
                at = loc;
                started[at] = ts;
                res.status = cslp_pkg::ST_OK;
                if (depth >= STACK_DEPTH) begin
                    res.status = cslp_pkg::ST_FULL;
                end else begin
                    nest[depth] = at;
                    depth++;
                end
                res.loc  = at;
                res.pred = lengths[at];
            end else if (depth == 0) begin
                res.loc    = '0;
                res.pred   = '0;
                res.status = cslp_pkg::ST_EMPTY;
            end else begin
                depth--;
                at = nest[depth];
                span = ts - started[at];
                d = span[cslp_pkg::PRED_W-1:0];
                lengths[at] = next_length(lengths[at], d);
                res.loc    = at;
                res.pred   = lengths[at];
                res.status = cslp_pkg::ST_OK;
            end
            pending.push_back(res);
        endfunction

        task report(string field, longint got, longint want);
            $display("MISMATCH %s at %0t: got %0d, expected %0d", field, $time, got, want);
            errors++;
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(logic [cslp_pkg::OUT_W-1:0] word);
            length_result_t                     want;
            logic [cslp_pkg::LOC_W-1:0]         loc;
            logic signed [cslp_pkg::PRED_W-1:0] pred;
            logic [cslp_pkg::STAT_W-1:0]        status;
            loc    = word[cslp_pkg::LOC_W-1:0];
            pred   = word[cslp_pkg::LOC_W+cslp_pkg::PRED_W-1:cslp_pkg::LOC_W];
            status = word[cslp_pkg::LOC_W+cslp_pkg::PRED_W+cslp_pkg::STAT_W-1:
                          cslp_pkg::LOC_W+cslp_pkg::PRED_W];
            if (pending.size() == 0) begin
                report("unexpected result, location_out", loc, 0);
                return;
            end
            want = pending.pop_front();
            if (loc !== want.loc) report("location_out", loc, want.loc);
            if (pred !== want.pred) report("prediction", pred, want.pred);
            if (status !== want.status) report("status", status, want.status);
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cslp_pkg::IN_W-1:0]      s_tdata;    // location, timestamp
    logic                           s_tuser;    // op
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cslp_pkg::OUT_W-1:0]     m_tdata;    // location_out, prediction, status
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [cslp_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    length_scoreboard               board;
    logic [cslp_pkg::TS_W-1:0]      clock_now;
    bit                             gapless;
    bit                             hold_request;
    int                             idle_cycles;

    critical_section_length_predictor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one event and hold it until the transfer
    task send_event(input logic op, input logic [cslp_pkg::LOC_W-1:0] loc,
                    input logic [cslp_pkg::TS_W-1:0] ts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {1'b0, ts, loc};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_event(op, loc, ts);
    endtask

    task write_limit(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.set_limit(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop the offer, drain every expected result, then let the block settle
    task wait_idle();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // Random timestamp: mostly forward steps, some long, some back, some noise
    function automatic logic [cslp_pkg::TS_W-1:0] pick_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            clock_now += $urandom_range(1, 3000);
            return clock_now;
        end
        if (r < 85) begin
            clock_now += $urandom_range(10000, 200000);
            return clock_now;
        end
        if (r < 93) return clock_now - $urandom_range(1, 5000);
        return {$urandom, $urandom};
    endfunction

    function automatic logic [cslp_pkg::LOC_W-1:0] pick_location();
        if ($urandom_range(0, 3) != 0) return cslp_pkg::LOC_W'($urandom_range(0, 7));
        return cslp_pkg::LOC_W'($urandom_range(0, LOCATIONS - 1));
    endfunction

    // Random walk over the nesting depth, mostly balanced pairs
    task run_random(input int count);
        logic op;
        int   r;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0) gapless = !gapless;
            r = $urandom_range(0, 99);
            if (board.depth == 0) begin
                op = (r < 10) ? cslp_pkg::OP_END : cslp_pkg::OP_START;
            end else if (board.depth >= STACK_DEPTH) begin
                op = (r < 80) ? cslp_pkg::OP_END : cslp_pkg::OP_START;
            end else begin
                op = (r < ((board.depth < 6) ? 55 : 35)) ? cslp_pkg::OP_START
                                                         : cslp_pkg::OP_END;
            end
            send_event(op, (op == cslp_pkg::OP_START) ? pick_location() : 7'($urandom),
                       pick_stamp());
        end
    endtask

    // Nest until the stack is full, overflow it, then unwind past empty
    task run_deep_nesting();
        while (board.depth < STACK_DEPTH)
            send_event(cslp_pkg::OP_START,
                       cslp_pkg::LOC_W'($urandom_range(0, LOCATIONS - 1)), pick_stamp());
        repeat (3) send_event(cslp_pkg::OP_START, pick_location(), pick_stamp());
        while (board.depth > 0) send_event(cslp_pkg::OP_END, 7'($urandom), pick_stamp());
        send_event(cslp_pkg::OP_END, 7'($urandom), pick_stamp());
    endtask

    // Repeated short sections on one location drive doubling to saturation
    task run_saturation();
        repeat (34) begin
            clock_now += $urandom_range(100, 500);
            send_event(cslp_pkg::OP_START, 7'd3, clock_now);
            clock_now += $urandom_range(1, 50);
            send_event(cslp_pkg::OP_END, 7'd3, clock_now);
        end
    endtask

    task run_directed();
        // Pop on an empty stack
        send_event(cslp_pkg::OP_END, 7'd0, 64'd0);
        // First section on a location takes the duration
        send_event(cslp_pkg::OP_START, 7'd0, 64'd0);
        send_event(cslp_pkg::OP_END, 7'h55, 64'd100);
        // Timestamp wrapping past all ones
        send_event(cslp_pkg::OP_START, 7'd127, '1);
        send_event(cslp_pkg::OP_END, 7'h2a, 64'd99);
        // Long duration on a small prediction doubles it
        send_event(cslp_pkg::OP_START, 7'd127, 64'h5555_5555_5555_5555);
        send_event(cslp_pkg::OP_END, 7'd0, 64'h5555_5555_5555_5555 + 64'd50000);
        // Negative duration through a borrow across bit 32
        send_event(cslp_pkg::OP_START, 7'd0, 64'h0000_0001_0000_0000);
        send_event(cslp_pkg::OP_END, 7'd0, 64'h0000_0000_FFFF_FFD8);
        // Duration with bit 31 set reads as a large negative value
        send_event(cslp_pkg::OP_START, 7'd85, 64'hAAAA_AAAA_AAAA_AAAA);
        send_event(cslp_pkg::OP_END, 7'd127, 64'hAAAA_AAAA_AAAA_AAAA + 64'h8000_0005);
        // Update on a negative prediction
        send_event(cslp_pkg::OP_START, 7'd85, 64'd1000);
        send_event(cslp_pkg::OP_END, 7'd0, 64'd1003);
        // Three deep nesting, unwound innermost first
        send_event(cslp_pkg::OP_START, 7'd42, 64'h1234);
        send_event(cslp_pkg::OP_START, 7'd1, 64'h2000);
        send_event(cslp_pkg::OP_START, 7'd2, 64'h2100);
        send_event(cslp_pkg::OP_END, 7'd0, 64'h2180);
        send_event(cslp_pkg::OP_END, 7'd0, 64'h2300);
        send_event(cslp_pkg::OP_END, 7'd0, 64'h4000);
        // Empty again after unwinding
        send_event(cslp_pkg::OP_END, 7'h7f, 64'h4001);
    endtask

    // Result side: ready runs and gaps, plus one long hold on request
    initial begin
        int run;
        int gap;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 30);
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        board        = new();
        clock_now    = {$urandom, $urandom};
        gapless      = 1'b0;
        hold_request = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= cslp_pkg::OP_START;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limits first
        run_directed();
        wait_idle();

        // Every positive duration long, every positive prediction but the largest small
        write_limit(cslp_pkg::REG_LONG_LIMIT, 32'h0000_0000);
        write_limit(cslp_pkg::REG_SMALL_LIMIT, 32'h7FFF_FFFF);
        run_saturation();
        run_random(90);
        wait_idle();

        // Doubling never applies
        write_limit(cslp_pkg::REG_LONG_LIMIT, 32'hFFFF_FFFF);
        write_limit(cslp_pkg::REG_SMALL_LIMIT, 32'h0000_0000);
        run_deep_nesting();
        run_random(90);
        wait_idle();

        // Random limits, top bit of the write data set at random
        write_limit(cslp_pkg::REG_LONG_LIMIT,
                    {1'($urandom), 31'($urandom_range(0, 40000))});
        write_limit(cslp_pkg::REG_SMALL_LIMIT,
                    {1'($urandom), 31'($urandom_range(0, 4000))});
        hold_request = 1'b1;
        run_random(100);
        wait_idle();

        // Back to the reset values, then a last random setting
        write_limit(cslp_pkg::REG_SMALL_LIMIT, {1'b1, cslp_pkg::SMALL_LIMIT_RST});
        write_limit(cslp_pkg::REG_LONG_LIMIT, {1'b0, cslp_pkg::LONG_LIMIT_RST});
        run_random(60);
        wait_idle();
        write_limit(cslp_pkg::REG_LONG_LIMIT, $urandom);
        write_limit(cslp_pkg::REG_SMALL_LIMIT, $urandom);
        run_random(60);

        wait_idle();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
